// ===== hdl/gvfc_pkg.sv =====
// ----------------------------------------------------------------------------
// gvfc_pkg: shared constants and tables for the ground velocity block
// Holds the fixed-point formats and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gvfc_pkg;

   localparam int TABLE_LEN = 24;

   // Angles in 1/64 degree.
   localparam logic [14:0] FULL_TURN    = 15'd23040;
   localparam logic [14:0] HALF_TURN    = 15'd11520;
   localparam logic [14:0] QUARTER_TURN = 15'd5760;

   localparam logic [29:0] GAIN_Q30  = 30'd652032875;
   localparam logic [16:0] SPEED_MAX = 17'd131071;

   // Internal angle width (2^-14 degree), unit vector width (Q30),
   // velocity sum width and vectoring datapath width (2^-16 knot).
   localparam int ZW = 24;
   localparam int RW = 32;
   localparam int EW = 36;
   localparam int VW = 38;

   // atan(2^-i) in 2^-14 degree, rounded to nearest.
   function automatic logic signed [ZW-1:0] atan_of(input int i);
      logic signed [ZW-1:0] a;
      case (i)
         0:  a = 24'sd737280;
         1:  a = 24'sd435242;
         2:  a = 24'sd229970;
         3:  a = 24'sd116736;
         4:  a = 24'sd58595;
         5:  a = 24'sd29326;
         6:  a = 24'sd14667;
         7:  a = 24'sd7334;
         8:  a = 24'sd3667;
         9:  a = 24'sd1833;
         10: a = 24'sd917;
         11: a = 24'sd458;
         12: a = 24'sd229;
         13: a = 24'sd115;
         14: a = 24'sd57;
         15: a = 24'sd29;
         16: a = 24'sd14;
         17: a = 24'sd7;
         18: a = 24'sd4;
         19: a = 24'sd2;
         20: a = 24'sd1;
         default: a = 24'sd0;
      endcase
      return a;
   endfunction

endpackage

// ===== hdl/gvfc_cordic.sv =====
// ----------------------------------------------------------------------------
// gvfc_cordic: pipelined CORDIC, one register stage per iteration
// Rotation mode steers by the sign of the angle, vectoring mode by the
// sign of y. A side tag and a valid bit travel with each transaction.
// ----------------------------------------------------------------------------
module gvfc_cordic #(
   parameter int STAGES    = 16,
   parameter int XW        = 32,
   parameter int TW        = 16,
   parameter bit VECTORING = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic signed [XW-1:0]          in_x,
   input  logic signed [XW-1:0]          in_y,
   input  logic signed [gvfc_pkg::ZW-1:0] in_z,
   input  logic [TW-1:0]                 in_tag,
   output logic                          out_valid,
   output logic signed [XW-1:0]          out_x,
   output logic signed [XW-1:0]          out_y,
   output logic signed [gvfc_pkg::ZW-1:0] out_z,
   output logic [TW-1:0]                 out_tag
);
   import gvfc_pkg::*;

   logic                 v_src [0:STAGES];
   logic signed [XW-1:0] x_src [0:STAGES];
   logic signed [XW-1:0] y_src [0:STAGES];
   logic signed [ZW-1:0] z_src [0:STAGES];
   logic [TW-1:0]        t_src [0:STAGES];

   assign v_src[0] = in_valid;
   assign x_src[0] = in_x;
   assign y_src[0] = in_y;
   assign z_src[0] = in_z;
   assign t_src[0] = in_tag;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic                 up;
      logic signed [XW-1:0] x_in, y_in, x_ff, y_ff;
      logic signed [ZW-1:0] z_in, z_ff;
      logic [TW-1:0]        t_ff;
      logic                 v_ff;

      assign up = VECTORING ? y_src[i][XW-1] : !z_src[i][ZW-1];

      always_comb begin
         if (up) begin
            x_in = x_src[i] - (y_src[i] >>> i);
            y_in = y_src[i] + (x_src[i] >>> i);
            z_in = z_src[i] - atan_of(i);
         end else begin
            x_in = x_src[i] + (y_src[i] >>> i);
            y_in = y_src[i] - (x_src[i] >>> i);
            z_in = z_src[i] + atan_of(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (enable) begin
            v_ff <= v_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
            t_ff <= t_src[i];
         end
      end

      assign v_src[i+1] = v_ff;
      assign x_src[i+1] = x_ff;
      assign y_src[i+1] = y_ff;
      assign z_src[i+1] = z_ff;
      assign t_src[i+1] = t_ff;
   end

   assign out_valid = v_src[STAGES];
   assign out_x     = x_src[STAGES];
   assign out_y     = y_src[STAGES];
   assign out_z     = z_src[STAGES];
   assign out_tag   = t_src[STAGES];

endmodule

// ===== hdl/ground_velocity_from_current.sv =====
// ----------------------------------------------------------------------------
// ground_velocity_from_current: course and speed over ground
// Adds a water velocity given in polar form to a current vector and
// returns the sum in polar form, using two pipelined CORDIC units.
// ----------------------------------------------------------------------------
// A request passes the pipeline registers and both CORDIC units on its way to
// its response; N = min(CORDIC_STAGES, 24) is the number of iterations in each CORDIC unit.
// Throughput: one transaction per cycle; every iteration has its own stage.
// The whole pipeline holds while a response waits under stall.
// Reset clears the valid bits of all stages; data registers are not reset.
module ground_velocity_from_current #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [14:0] req_water_heading,
   input  logic [15:0] req_water_speed,
   input  logic signed [15:0] req_current_east,
   input  logic signed [15:0] req_current_north,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_ground_course,
   output logic [16:0] rsp_ground_speed
);
   import gvfc_pkg::*;

   // Iteration count is limited by the size of the arctangent table.
   localparam int N = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

   // All stages move together; the pipeline only holds when the output
   // register is full and the consumer stalls it.
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---------------------------------------------------------------------
   // Stage 0: heading reduction into -90..90 degrees for the rotation.
   // ---------------------------------------------------------------------
   logic [14:0]        head_in;
   logic signed [15:0] d_wrap, d_in;
   logic               flip_in;

   always_comb begin
      head_in = (req_water_heading >= FULL_TURN) ?
                req_water_heading - FULL_TURN : req_water_heading;
      d_wrap  = (head_in >= HALF_TURN) ?
                $signed({1'b0, head_in}) - $signed({1'b0, FULL_TURN}) :
                $signed({1'b0, head_in});
      flip_in = 1'b0;
      d_in    = d_wrap;
      if (d_wrap > $signed({1'b0, QUARTER_TURN})) begin
         d_in    = d_wrap - $signed({1'b0, HALF_TURN});
         flip_in = 1'b1;
      end else if (d_wrap < -$signed({1'b0, QUARTER_TURN})) begin
         d_in    = d_wrap + $signed({1'b0, HALF_TURN});
         flip_in = 1'b1;
      end
   end

   logic               v0_ff, flip0_ff;
   logic [14:0]        head0_ff;
   logic [15:0]        spd0_ff;
   logic signed [15:0] ce0_ff, cn0_ff, d0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head0_ff <= head_in;
         flip0_ff <= flip_in;
         d0_ff    <= d_in;
         spd0_ff  <= req_water_speed;
         ce0_ff   <= req_current_east;
         cn0_ff   <= req_current_north;
      end
   end

   // ---------------------------------------------------------------------
   // Rotation CORDIC: unit vector at the reduced heading, x = cos, y = sin.
   // The tag carries the heading, speed, current and the half-turn flag.
   // ---------------------------------------------------------------------
   localparam int RTW = 64;
   logic                 rot_valid;
   logic signed [RW-1:0] rot_x, rot_y;
   logic signed [ZW-1:0] rot_z;
   logic [RTW-1:0]       rot_tag;
   logic signed [ZW-1:0] rot_z_in;

   // The reduced heading scaled to the internal angle unit.
   assign rot_z_in = ZW'($signed({d0_ff, 8'd0}));

   gvfc_cordic #(
      .STAGES(N), .XW(RW), .TW(RTW), .VECTORING(1'b0)
   ) u_rotate (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (v0_ff),
      .in_x     ($signed({{(RW-30){1'b0}}, GAIN_Q30})),
      .in_y     ({RW{1'b0}}),
      .in_z     (rot_z_in),
      .in_tag   ({flip0_ff, head0_ff, spd0_ff, ce0_ff, cn0_ff}),
      .out_valid(rot_valid),
      .out_x    (rot_x),
      .out_y    (rot_y),
      .out_z    (rot_z),
      .out_tag  (rot_tag)
   );

   // The rotation's residual angle is not needed further on.
   logic rot_z_unused;
   assign rot_z_unused = ^rot_z;

   // ---------------------------------------------------------------------
   // Stage 1: undo the half-turn reduction and scale by the water speed.
   // ---------------------------------------------------------------------
   logic                 r_flip;
   logic [14:0]          r_head;
   logic [15:0]          r_spd;
   logic signed [15:0]   r_ce, r_cn;
   logic signed [RW-1:0] cos_v, sin_v;

   assign {r_flip, r_head, r_spd, r_ce, r_cn} = rot_tag;
   assign cos_v = r_flip ? -rot_x : rot_x;
   assign sin_v = r_flip ? -rot_y : rot_y;

   logic                 v1_ff;
   logic [14:0]          head1_ff;
   logic signed [15:0]   ce1_ff, cn1_ff;
   logic signed [RW+16:0] pe1_ff, pn1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= rot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head1_ff <= r_head;
         ce1_ff   <= r_ce;
         cn1_ff   <= r_cn;
         pe1_ff   <= $signed({1'b0, r_spd}) * sin_v;
         pn1_ff   <= $signed({1'b0, r_spd}) * cos_v;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: round to 2^-16 knot and add the current.
   // ---------------------------------------------------------------------
   logic signed [RW+16:0] pe_rnd, pn_rnd;
   logic signed [EW-1:0]  e_in, n_in;

   always_comb begin
      pe_rnd = pe1_ff + $signed((RW+17)'(1 << 13));
      pn_rnd = pn1_ff + $signed((RW+17)'(1 << 13));
      e_in = $signed({pe_rnd[RW+16], pe_rnd[RW+16:14]})
           + $signed({{(EW-32){ce1_ff[15]}}, ce1_ff, 16'd0});
      n_in = $signed({pn_rnd[RW+16], pn_rnd[RW+16:14]})
           + $signed({{(EW-32){cn1_ff[15]}}, cn1_ff, 16'd0});
   end

   logic                 v2_ff;
   logic [14:0]          head2_ff;
   logic signed [EW-1:0] e2_ff, n2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head2_ff <= head1_ff;
         e2_ff    <= e_in;
         n2_ff    <= n_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: zero detect, and a vector pointing south is negated so the
   // vectoring starts from the right half plane at a half turn.
   // ---------------------------------------------------------------------
   logic                 v3_ff, zero3_ff;
   logic [14:0]          head3_ff;
   logic signed [VW-1:0] vx3_ff, vy3_ff;
   logic signed [ZW-1:0] vz3_ff;
   logic signed [VW-1:0] e_ext, n_ext;

   assign e_ext = {{(VW-EW){e2_ff[EW-1]}}, e2_ff};
   assign n_ext = {{(VW-EW){n2_ff[EW-1]}}, n2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head3_ff <= head2_ff;
         zero3_ff <= (e2_ff == '0) && (n2_ff == '0);
         if (n2_ff[EW-1]) begin
            vx3_ff <= -n_ext;
            vy3_ff <= -e_ext;
            vz3_ff <= $signed({{(ZW-23){1'b0}}, HALF_TURN, 8'd0});
         end else begin
            vx3_ff <= n_ext;
            vy3_ff <= e_ext;
            vz3_ff <= '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Vectoring CORDIC: angle from north and scaled magnitude.
   // ---------------------------------------------------------------------
   logic                 vec_valid;
   logic signed [VW-1:0] vec_x, vec_y;
   logic signed [ZW-1:0] vec_z;
   logic [15:0]          vec_tag;

   gvfc_cordic #(
      .STAGES(N), .XW(VW), .TW(16), .VECTORING(1'b1)
   ) u_vector (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (v3_ff),
      .in_x     (vx3_ff),
      .in_y     (vy3_ff),
      .in_z     (vz3_ff),
      .in_tag   ({zero3_ff, head3_ff}),
      .out_valid(vec_valid),
      .out_x    (vec_x),
      .out_y    (vec_y),
      .out_z    (vec_z),
      .out_tag  (vec_tag)
   );

   logic vec_y_unused;
   assign vec_y_unused = ^vec_y;

   // ---------------------------------------------------------------------
   // Stage 4: gain correction as two partial products. The vectoring x
   // never goes negative, so it is treated as unsigned.
   // ---------------------------------------------------------------------
   logic                 v4_ff, zero4_ff;
   logic [14:0]          head4_ff;
   logic signed [ZW-1:0] z4_ff;
   logic [47:0]          pplo4_ff;
   logic [VW-20:0]       pphi_in;
   logic [VW+10:0]       pphi4_ff;

   assign pphi_in = vec_x[VW-2:18];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= vec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         {zero4_ff, head4_ff} <= vec_tag;
         z4_ff    <= vec_z;
         pplo4_ff <= vec_x[17:0] * GAIN_Q30;
         pphi4_ff <= pphi_in * GAIN_Q30;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: combine the partial products and round away the Q30 scale.
   // ---------------------------------------------------------------------
   localparam int FW = VW + 30;
   logic [FW-1:0] full_sum;

   assign full_sum = ({{(FW-VW-11){1'b0}}, pphi4_ff} << 18)
                   + {{(FW-48){1'b0}}, pplo4_ff}
                   + FW'(1 << 29);

   logic                 v5_ff, zero5_ff;
   logic [14:0]          head5_ff;
   logic signed [ZW-1:0] z5_ff;
   logic [FW-31:0]       mag5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero5_ff <= zero4_ff;
         head5_ff <= head4_ff;
         z5_ff    <= z4_ff;
         mag5_ff  <= full_sum[FW-1:30];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: output register. Speed rounds to 1/256 knot and saturates;
   // course rounds to 1/64 degree and wraps once into a full turn. A zero
   // sum reports the request heading, wrapped into a full turn, at zero speed.
   // ---------------------------------------------------------------------
   logic [FW-30:0]       mag_rnd;
   logic [FW-38:0]       mag_q;
   logic [16:0]          speed_in;
   logic signed [ZW-1:0] z_rnd;
   logic signed [ZW-9:0] crs_raw;
   logic signed [ZW-9:0] crs_fix;
   logic [14:0]          course_in;

   always_comb begin
      mag_rnd  = {1'b0, mag5_ff} + (FW-29)'(128);
      mag_q    = mag_rnd[FW-30:8];
      speed_in = (mag_q > (FW-37)'(SPEED_MAX)) ? SPEED_MAX : mag_q[16:0];
      z_rnd    = z5_ff + ZW'(128);
      crs_raw  = z_rnd[ZW-1:8];
      if (crs_raw < 0) begin
         crs_fix = crs_raw + $signed({1'b0, FULL_TURN});
      end else if (crs_raw >= $signed({1'b0, FULL_TURN})) begin
         crs_fix = crs_raw - $signed({1'b0, FULL_TURN});
      end else begin
         crs_fix = crs_raw;
      end
      course_in = crs_fix[14:0];
   end

   logic        v6_ff;
   logic [14:0] course6_ff;
   logic [16:0] speed6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         course6_ff <= zero5_ff ? head5_ff : course_in;
         speed6_ff  <= zero5_ff ? 17'd0 : speed_in;
      end
   end

   assign rsp_valid         = v6_ff;
   assign rsp_ground_course = course6_ff;
   assign rsp_ground_speed  = speed6_ff;

endmodule

// ===== hdl/gvfc_checker.sv =====
// ----------------------------------------------------------------------------
// gvfc_checker: port-level checks for the ground velocity block
// Watches the request and response handshakes and the course range.
// ----------------------------------------------------------------------------
module gvfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [14:0] rsp_ground_course,
   input logic [16:0] rsp_ground_speed
);
   import gvfc_pkg::*;

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The request side only stalls when the response is held.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

   // A stalled request stays offered until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> req_valid)
      else $error("stalled request withdrawn");

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ground_course)
                                    && $stable(rsp_ground_speed)))
      else $error("held response changed");

   // Course is always within one full turn.
   a_course_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ground_course < FULL_TURN))
      else $error("course out of range");

endmodule

bind ground_velocity_from_current gvfc_checker u_gvfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_ground_course(rsp_ground_course),
   .rsp_ground_speed (rsp_ground_speed)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for ground_velocity_from_current
// Drives headings, water speeds and currents through the valid/stall request
// channel and compares each response against a bit-exact CORDIC predictor.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gvfc_pkg::*;

   localparam int STAGES  = 16;
   localparam int LATENCY = 2 * STAGES + 7;

   typedef struct packed {
      logic [14:0] course;
      logic [16:0] speed;
   } ground_fix_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [14:0] req_water_heading;
   logic [15:0] req_water_speed;
   logic signed [15:0] req_current_east;
   logic signed [15:0] req_current_north;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [14:0] rsp_ground_course;
   logic [16:0] rsp_ground_speed;

   ground_fix_type pending_fixes[$];
   int          mismatches;
   bit          hold_active;   // the long receiver hold-off is in progress
   bit          rsp_random_on; // random response stalls enabled

   ground_velocity_from_current #(.CORDIC_STAGES(STAGES)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   // Arctangent table in 2^-14 degree, with the same values as the package table.
   function automatic longint atan_step(input int i);
      longint tab[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                          3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};
      return tab[i];
   endfunction

   // Rounding right shift: add half, then floor (>>> on longint is a floor shift).
   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // Predicts course and speed over ground for one request.
   function automatic ground_fix_type predict_ground_fix(input logic [14:0] heading,
         input logic [15:0] speed, input logic signed [15:0] cur_e,
         input logic signed [15:0] cur_n);
      longint hd, d, x, y, z, t, e, n, mag, crs;
      bit flip;
      ground_fix_type r;
      hd = heading;
      if (hd >= 23040) hd -= 23040;
      d = hd;
      flip = 0;
      if (d >= 11520) d -= 23040;
      if (d > 5760) begin
         d -= 11520;
         flip = 1;
      end else if (d < -5760) begin
         d += 11520;
         flip = 1;
      end
      x = 652032875;
      y = 0;
      z = d * 256;
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_step(i);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_step(i);
         end
         x = t;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      e = round_shift(longint'(speed) * y, 14) + longint'(cur_e) * 65536;
      n = round_shift(longint'(speed) * x, 14) + longint'(cur_n) * 65536;
      if (e == 0 && n == 0) begin
         r.course = hd[14:0];
         r.speed = '0;
         return r;
      end
      x = n;
      y = e;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 11520 * 256;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (y >= 0) begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_step(i);
         end else begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_step(i);
         end
         x = t;
      end
      mag = round_shift(round_shift(x * 652032875, 30), 8);
      if (mag < 0) mag = 0;
      if (mag > 131071) mag = 131071;
      crs = round_shift(z, 8);
      while (crs < 0) crs += 23040;
      while (crs >= 23040) crs -= 23040;
      r.course = crs[14:0];
      r.speed = mag[16:0];
      return r;
   endfunction

   // Sends one request transaction after a random gap; the payload is held
   // while the block stalls, and the prediction is queued at acceptance.
   // Valid drops only when a gap follows, so back-to-back transactions keep
   // it high and each step sees a single assignment to it.
   task automatic send_request(input logic [14:0] hd, input logic [15:0] sp,
         input logic signed [15:0] ce, input logic signed [15:0] cn, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_water_heading <= hd;
      req_water_speed <= sp;
      req_current_east <= ce;
      req_current_north <= cn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_fixes.push_back(predict_ground_fix(hd, sp, ce, cn));
   endtask

   task automatic finish_burst();
      req_valid <= 1'b0;
   endtask

   // Response stall: random per transaction, or forced high during the hold-off.
   initial begin
      int wait_cycles;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_active) begin
            rsp_stall <= 1'b1;
         end else if (rsp_random_on && rsp_valid && !rsp_stall) begin
            wait_cycles = $urandom_range(0, 11);
            if (wait_cycles > 0 && $urandom_range(0, 2) == 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Checks each accepted response against the oldest prediction.
   always @(posedge clock) begin
      ground_fix_type exp_fix;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_fixes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: course %0d speed %0d",
                        rsp_ground_course, rsp_ground_speed);
         end else begin
            exp_fix = pending_fixes.pop_front();
            if (rsp_ground_course !== exp_fix.course || rsp_ground_speed !== exp_fix.speed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: course exp %0d got %0d, speed exp %0d got %0d",
                           exp_fix.course, rsp_ground_course, exp_fix.speed,
                           rsp_ground_speed);
            end
         end
      end
   end

   // Extremes of every field and the special cases: headings out of range,
   // the angle reduction boundaries, negative north sums and zero sums.
   task automatic test_directed();
      send_request(15'd0, 16'd0, 16'sd0, 16'sd0, 0);
      send_request(15'd32767, 16'd0, 16'sd0, 16'sd0, 0);
      send_request(15'd23040, 16'd1000, 16'sd0, 16'sd0, 0);
      send_request(15'd23039, 16'd65535, 16'sd32767, 16'sd32767, 0);
      send_request(15'd5760, 16'd65535, -16'sd32768, -16'sd32768, 0);
      send_request(15'd5761, 16'd256, 16'sd0, 16'sd0, 0);
      send_request(15'd17280, 16'd256, 16'sd0, 16'sd0, 0);
      send_request(15'd17279, 16'd256, 16'sd0, 16'sd0, 0);
      send_request(15'd11520, 16'd65535, 16'sd0, 16'sd0, 0);
      send_request(15'd11519, 16'd1, 16'sd0, 16'sd0, 0);
      send_request(15'd0, 16'd256, 16'sd0, -16'sd1, 0);
      send_request(15'd0, 16'd256, 16'sd0, -16'sd256, 0);
      send_request(15'd11520, 16'd256, 16'sd0, 16'sd256, 0);
      send_request(15'd5760, 16'd256, -16'sd256, 16'sd0, 0);
      send_request(15'd100, 16'd0, 16'sd0, -16'sd32768, 0);
      send_request(15'd100, 16'd0, 16'sd32767, 16'sd0, 0);
      send_request(15'd30000, 16'd0, 16'sd0, 16'sd0, 0);
      send_request(15'd2880, 16'd65535, 16'sd32767, 16'sd32767, 0);
      send_request(15'd14400, 16'd65535, -16'sd32768, -16'sd32768, 0);
      send_request(15'd16384, 16'd32768, 16'sd1, 16'sd1, 0);
   endtask

   // Random requests; the sender's gaps and occasional back-to-back bursts
   // mix with random response stalls.
   task automatic test_random(input int count);
      logic [14:0] hd;
      logic signed [15:0] ce, cn;
      bit burst;
      for (int k = 0; k < count; k++) begin
         hd = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23039));
         ce = 16'($urandom);
         cn = 16'($urandom);
         if ($urandom_range(0, 7) == 0) begin
            ce = 16'sd0;
            cn = 16'sd0;
         end
         burst = ($urandom_range(0, 4) == 0) && (k != count - 1);
         send_request(hd, 16'($urandom), ce, cn, burst);
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the pipeline fills and the block stalls its input.
   task automatic test_backpressure();
      fork
         begin
            hold_active = 1'b1;
            repeat (LATENCY * 3) @(posedge clock);
            hold_active = 1'b0;
         end
         begin
            for (int k = 0; k < 100; k++)
               send_request(15'($urandom_range(0, 23039)), 16'($urandom), 16'($urandom),
                            16'($urandom), k != 99);
         end
      join
   endtask

   initial begin
      mismatches = 0;
      hold_active = 1'b0;
      rsp_random_on = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_water_heading = '0;
      req_water_speed = '0;
      req_current_east = '0;
      req_current_north = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      rsp_random_on = 1'b1;
      test_random(900);
      test_backpressure();
      test_random(930);
      finish_burst();
      while (pending_fixes.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && pending_fixes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
